// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  localparam int TickW = 16;
  localparam int CodeW = 8;

  localparam logic [CodeW-1:0] CODE_LONG      = 8'hFF;
  localparam logic [CodeW-1:0] CODE_MAX_COUNT = 8'd254;
  localparam logic [CodeW-1:0] CODE_FIRST     = 8'd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE       = 2'd0,
    ACT_READ_PRESS   = 2'd1,
    ACT_READ_RELEASE = 2'd2,
    ACT_READ_CODE    = 2'd3
  } action_t;

  typedef enum logic {
    REG_MULTI_CLICK_WINDOW = 1'b0,
    REG_LONG_PRESS_LIMIT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    action_t          action;
    logic [TickW-1:0] tick_count;
    logic             pin_level;
  } item_t;

  typedef struct packed {
    logic             event_seen;
    logic [CodeW-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic [TickW-1:0] multi_click_window;
    logic [TickW-1:0] long_press_limit;
  } cfg_t;

endpackage

// ===== design/bcc_core.sv =====
module bcc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  bcc_pkg::item_t  item,
  input  bcc_pkg::cfg_t   cfg,
  output bcc_pkg::result_t result
);
  import bcc_pkg::*;

  logic             last_level_r, last_level_nxt;
  logic [TickW-1:0] press_time_r, press_time_nxt;
  logic [TickW-1:0] release_time_r, release_time_nxt;
  logic             press_flag_r, press_flag_nxt;
  logic             release_flag_r, release_flag_nxt;
  logic             expired_r, expired_nxt;
  logic [CodeW-1:0] click_code_r, click_code_nxt;

  logic [TickW-1:0] since_release;
  logic [TickW-1:0] since_press;
  logic             falling;
  logic             rising;

  assign since_release = item.tick_count - release_time_r;
  assign since_press   = item.tick_count - press_time_r;
  assign falling       = last_level_r && !item.pin_level;
  assign rising        = !last_level_r && item.pin_level;

  always_comb begin
    last_level_nxt   = last_level_r;
    press_time_nxt   = press_time_r;
    release_time_nxt = release_time_r;
    press_flag_nxt   = press_flag_r;
    release_flag_nxt = release_flag_r;
    expired_nxt      = expired_r;
    click_code_nxt   = click_code_r;
    result           = '0;
    unique case (item.action)
      ACT_SAMPLE: begin
        last_level_nxt = item.pin_level;
        if (falling) begin
          press_time_nxt   = item.tick_count;
          press_flag_nxt   = 1'b1;
          release_flag_nxt = 1'b0;
          if (expired_r) begin
            click_code_nxt = CODE_FIRST;
          end else if (click_code_r >= CODE_MAX_COUNT) begin
            click_code_nxt = CODE_MAX_COUNT;
          end else begin
            click_code_nxt = click_code_r + CODE_FIRST;
          end
          result.event_seen = 1'b1;
        end else if (rising) begin
          release_time_nxt  = item.tick_count;
          press_flag_nxt    = 1'b0;
          release_flag_nxt  = 1'b1;
          expired_nxt       = (click_code_r == CODE_LONG);
          result.event_seen = 1'b1;
        end else if (item.pin_level) begin
          if (since_release >= cfg.multi_click_window) begin
            expired_nxt       = 1'b1;
            result.event_seen = 1'b1;
          end
        end else begin
          if (since_press >= cfg.long_press_limit) begin
            click_code_nxt    = CODE_LONG;
            result.event_seen = 1'b1;
          end
        end
      end
      ACT_READ_PRESS: begin
        result.read_value = {{(CodeW-1){1'b0}}, press_flag_r};
        press_flag_nxt    = 1'b0;
      end
      ACT_READ_RELEASE: begin
        result.read_value = {{(CodeW-1){1'b0}}, release_flag_r};
        release_flag_nxt  = 1'b0;
      end
      ACT_READ_CODE: begin
        if (release_flag_r && expired_r) begin
          press_flag_nxt    = 1'b0;
          release_flag_nxt  = 1'b0;
          result.read_value = click_code_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      press_time_r   <= '0;
      release_time_r <= '0;
      press_flag_r   <= 1'b0;
      release_flag_r <= 1'b0;
      expired_r      <= 1'b0;
      click_code_r   <= '0;
    end else if (advance) begin
      last_level_r   <= last_level_nxt;
      press_time_r   <= press_time_nxt;
      release_time_r <= release_time_nxt;
      press_flag_r   <= press_flag_nxt;
      release_flag_r <= release_flag_nxt;
      expired_r      <= expired_nxt;
      click_code_r   <= click_code_nxt;
    end
  end

endmodule

// ===== design/button_click_classifier.sv =====
// One active-low push button classifier (press/release flags, multi-click count,
// long press). An item is registered on input, classified against the button
// state in a single combinational pass and held in an output register, so the
// block takes one item per clock; stalls on the output only hold the pipeline.
// Configuration writes are always ready.
module button_click_classifier (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // tick_count[15:0], pin_level[16], zeros
  input  logic [1:0]                 in_tuser,   // action[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // event_seen[0], read_value[8:1], zeros
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bcc_pkg::TickW-1:0]  cfg_data
);
  import bcc_pkg::*;

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;
  cfg_t    cfg_r;
  logic    advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.action     <= action_t'(in_tuser);
      in_item_r.tick_count <= in_tdata[TickW-1:0];
      in_item_r.pin_level  <= in_tdata[TickW];
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.multi_click_window <= '1;
      cfg_r.long_press_limit   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MULTI_CLICK_WINDOW: cfg_r.multi_click_window <= cfg_data;
        REG_LONG_PRESS_LIMIT:   cfg_r.long_press_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  bcc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.read_value, out_res_r.event_seen};

endmodule

// ===== design/bcc_chk.sv =====
module bcc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_event_or_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("sample event carries a read value");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted item not delivered in two cycles");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind button_click_classifier bcc_chk u_bcc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
